@@ src/isqrt64_pkg.sv @@
// isqrt64_pkg: shared types and constants for the 64-bit integer square root.
// Used by isqrt64_cell and integer_square_root_64; no dependencies.
`timescale 1ns / 1ps
package isqrt64_pkg;

   localparam int RAD_W     = 64;             // radicand width
   localparam int ROOT_W    = 32;             // root width
   localparam int STEPS     = RAD_W / 2;      // one root bit per step
   localparam int NUM_CELLS = ROOT_W / 2 + 1; // 2-bit slices, 34-bit remainder
   localparam int CNT_W     = $clog2(STEPS);

   typedef logic [1:0] digit_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic step;     // cells load their next state
      logic restart;  // cells treat their held state as zero
      logic take;     // subtract accepted: root bit is one
   } cell_ctrl_type;

endpackage

@@ src/isqrt64_cell.sv @@
// isqrt64_cell: one 2-bit slice of remainder and partial root, with its
// slice of the borrow chain. Depends on isqrt64_pkg.
`timescale 1ns / 1ps
module isqrt64_cell (
   input  logic                       clock,
   input  isqrt64_pkg::cell_ctrl_type ctrl,
   input  isqrt64_pkg::digit_type     rem_link_i,  // lower neighbor's remainder pair
   input  isqrt64_pkg::digit_type     trial_i,     // trial pair (root shifted by two)
   input  logic                       shift_i,     // root bit shifted in from below
   input  logic                       borrow_i,
   output logic                       borrow_o,
   output isqrt64_pkg::digit_type     rem_link_o,
   output isqrt64_pkg::digit_type     root_link_o,
   output isqrt64_pkg::digit_type     root_o
);
   import isqrt64_pkg::*;

   digit_type  rem_ff;
   digit_type  root_ff;
   digit_type  rem_in;
   digit_type  root_in;
   logic [2:0] diff;

   // held state reads as zero on the restart step
   assign rem_link_o  = ctrl.restart ? 2'b00 : rem_ff;
   assign root_link_o = ctrl.restart ? 2'b00 : root_ff;
   assign root_o      = root_ff;

   assign diff     = {1'b0, rem_link_i} - {1'b0, trial_i} - {2'b00, borrow_i};
   assign borrow_o = diff[2];

   assign rem_in  = ctrl.take ? diff[1:0] : rem_link_i;
   assign root_in = {root_link_o[0], shift_i};

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

@@ src/integer_square_root_64.sv @@
// integer_square_root_64: floor square root of a 64-bit unsigned radicand.
// Depends on isqrt64_pkg and isqrt64_cell.
`timescale 1ns / 1ps
// Usage
//   Request: drive req_radicand and raise start. The request is taken at a
//   rising edge where start is high and busy is low.
//   Response: rsp_valid is high for exactly one cycle with rsp_root, the
//   floor square root. The receiver cannot stall; it must take the response
//   in that cycle.
//   Overlap: busy rises at the accept edge and is already low in the strobe
//   cycle, so a new request may be taken there.
//   Rate is set by the digit recurrence: one root bit per cycle, resolved by
//   a single 34-bit borrow ripple through a row of 17 two-bit cells.
//   Each cycle the radicand feeds two bits into the bottom cell, each cell
//   passes its remainder pair up to its neighbor, and the root shifts left
//   by one bit through the cells.
//   Reset: clears busy and the response strobe; an in-flight request is
//   dropped. The cell datapath needs no reset, since the accept step masks it.
module integer_square_root_64 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [isqrt64_pkg::RAD_W-1:0]    req_radicand,
   output logic                             rsp_valid,
   output logic [isqrt64_pkg::ROOT_W-1:0]   rsp_root
);
   import isqrt64_pkg::*;

   localparam int LAST = NUM_CELLS - 1;

   logic                     busy_ff;
   logic                     busy_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [CNT_W-1:0]         cnt_ff;      // busy steps still to run, counting the current one
   logic [CNT_W-1:0]         cnt_in;
   logic [RAD_W-1:0]         rad_ff;      // radicand digit feed, top pair first
   logic [RAD_W-1:0]         rad_in;

   logic                     accept;
   cell_ctrl_type            ctrl;
   digit_type                feed_pair;
   logic [NUM_CELLS:0]       borrow;
   digit_type                rem_link  [NUM_CELLS];
   digit_type                root_link [NUM_CELLS];
   digit_type                rem_top;
   logic [2*NUM_CELLS-1:0]   root_all;

   assign accept = start && !busy_ff;

   // ---------------------------------------------------------------
   // Sequencer: accept step, then STEPS-1 busy steps
   // ---------------------------------------------------------------
   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // ---------------------------------------------------------------
   // Radicand feed: the accept step consumes the top pair directly
   // ---------------------------------------------------------------
   assign feed_pair = accept ? req_radicand[RAD_W-1 -: 2] : rad_ff[RAD_W-1 -: 2];
   assign rad_in    = accept ? {req_radicand[RAD_W-3:0], 2'b00}
                             : {rad_ff[RAD_W-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         rad_ff <= rad_in;
      end
   end

   // ---------------------------------------------------------------
   // Cell row: remainder minus (root*4 + 1), borrow rippling upward
   // ---------------------------------------------------------------
   assign borrow[0]    = 1'b0;
   assign ctrl.step    = accept || busy_ff;
   assign ctrl.restart = accept;
   assign ctrl.take    = !borrow[NUM_CELLS];  // no borrow: remainder >= trial

   genvar j;
   generate
      for (j = 0; j < NUM_CELLS; j++) begin : g_cell
         digit_type rem_src;
         digit_type trial_src;
         logic      shift_src;

         if (j == 0) begin : g_bottom
            assign rem_src   = feed_pair;
            assign trial_src = 2'b01;
            assign shift_src = ctrl.take;
         end else begin : g_upper
            assign rem_src   = rem_link[j-1];
            assign trial_src = root_link[j-1];
            assign shift_src = root_link[j-1][1];
         end

         isqrt64_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .rem_link_i  (rem_src),
            .trial_i     (trial_src),
            .shift_i     (shift_src),
            .borrow_i    (borrow[j]),
            .borrow_o    (borrow[j+1]),
            .rem_link_o  (rem_link[j]),
            .root_link_o (root_link[j]),
            .root_o      (root_all[2*j +: 2])
         );
      end
   endgenerate

   assign rem_top = rem_link[LAST];

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = root_all[ROOT_W-1:0];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Every accepted request is answered by the response strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(STEPS) rsp_valid_ff)
      else $error("response strobe missing after fixed latency");

   // busy only drops together with the response strobe.
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff)
      else $error("busy dropped without a response");

   // Mid-computation the remainder and root stay below 2^32.
   a_headroom: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_top == 2'b00) && (root_link[LAST] == 2'b00))
      else $error("cell row overflow into top slice");

   // The finished root fits in 32 bits.
   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (root_all[2*NUM_CELLS-1:ROOT_W] == '0))
      else $error("root exceeds 32 bits");

endmodule
